/* hdl/dsa_pkg.sv */
// Shared types and constants for the dual stack with append block.
// Used by dsa_ctrl, dsa_dp and dual_stack_with_append_core; no dependencies.
package dsa_pkg;

	localparam int FIRST_DEPTH_DEF  = 8;
	localparam int SECOND_DEPTH_DEF = 8;

	typedef enum logic [1:0] {
		OP_PUSH   = 2'd0,
		OP_POP    = 2'd1,
		OP_APPEND = 2'd2
	} dsa_op_t;

	typedef enum logic [2:0] {
		ST_OK           = 3'd0,
		ST_FULL         = 3'd1,
		ST_EMPTY        = 3'd2,
		ST_APPEND_EMPTY = 3'd3,
		ST_NO_FIT       = 3'd4
	} dsa_status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP_RD,
		S_COPY,
		S_RESP
	} dsa_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic exec;
		logic pop_cap;
		logic copy;
	} dsa_ctl_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic go_pop;
		logic go_copy;
		logic copy_done;
	} dsa_stat_t;

endpackage

/* hdl/dsa_ctrl.sv */
// Controller state machine for the dual stack with append block.
// Depends on dsa_pkg; drives dsa_dp through dsa_ctl_t and reads dsa_stat_t.
module dsa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  dsa_pkg::dsa_stat_t stat,
	output dsa_pkg::dsa_ctl_t  ctl,
	output logic               busy,
	output logic               done
);
	import dsa_pkg::*;

	dsa_state_t state_q;
	dsa_state_t state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	always_comb begin
		state_nxt = state_q;
		ctl       = '0;
		busy      = 1'b1;
		done      = 1'b0;
		case (state_q)
			S_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = S_EXEC;
				end
			end
			S_EXEC: begin
				ctl.exec = 1'b1;
				if (stat.go_pop) begin
					state_nxt = S_POP_RD;
				end else if (stat.go_copy) begin
					state_nxt = S_COPY;
				end else begin
					state_nxt = S_RESP;
				end
			end
			S_POP_RD: begin
				ctl.pop_cap = 1'b1;
				state_nxt   = S_RESP;
			end
			S_COPY: begin
				ctl.copy = 1'b1;
				if (stat.copy_done) begin
					state_nxt = S_RESP;
				end
			end
			S_RESP: begin
				// The result registers hold through this cycle, so a new word
				// can be taken while the result is shown.
				done = 1'b1;
				busy = 1'b0;
				if (start) begin
					ctl.load  = 1'b1;
					state_nxt = S_EXEC;
				end else begin
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

endmodule

/* hdl/dsa_dp.sv */
// Datapath for the dual stack with append block: both stack memories, the
// counts, the copy engine and the result registers. Depends on dsa_pkg.
module dsa_dp #(
	parameter int FIRST_DEPTH  = dsa_pkg::FIRST_DEPTH_DEF,
	parameter int SECOND_DEPTH = dsa_pkg::SECOND_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dsa_pkg::dsa_ctl_t  ctl,
	output dsa_pkg::dsa_stat_t stat,
	input  logic [1:0]         cmd,
	input  logic               which_stack,
	input  logic signed [31:0] push_value,
	output logic [2:0]         status,
	output logic signed [31:0] pop_value,
	output logic               append_target
);
	import dsa_pkg::*;

	localparam int CW1  = $clog2(FIRST_DEPTH + 1);
	localparam int CW2  = $clog2(SECOND_DEPTH + 1);
	localparam int AW1  = (FIRST_DEPTH > 1) ? $clog2(FIRST_DEPTH) : 1;
	localparam int AW2  = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
	localparam int XW   = (CW1 > CW2) ? CW1 : CW2;
	localparam int SUMW = XW + 1;

	logic [31:0] f_mem [FIRST_DEPTH];
	logic [31:0] s_mem [SECOND_DEPTH];
	logic [31:0] f_rdata_q;
	logic [31:0] s_rdata_q;

	logic [1:0]  cmd_q;
	logic        sel_q;
	logic [31:0] push_value_q;

	logic [CW1-1:0] first_cnt_q;
	logic [CW2-1:0] second_cnt_q;

	logic [XW-1:0] len_q;
	logic [XW-1:0] rd_idx_q;
	logic [XW-1:0] wr_idx_q;
	logic          wr_pend_q;
	logic          to_second_q;

	logic [2:0]  status_q;
	logic [31:0] pop_value_q;
	logic        target_q;

	logic [SUMW-1:0] total;
	logic f_full, s_full, f_empty, s_empty;
	logic is_push, is_pop, is_app;
	logic push_ok, pop_ok, both, fit_second, fit_first, copy_go, copy_done;
	logic [2:0] status_nxt;

	logic           f_we, s_we;
	logic [AW1-1:0] f_waddr, f_raddr;
	logic [AW2-1:0] s_waddr, s_raddr;
	logic [31:0]    f_wdata, s_wdata;

	always_comb begin
		f_full     = first_cnt_q == CW1'(FIRST_DEPTH);
		s_full     = second_cnt_q == CW2'(SECOND_DEPTH);
		f_empty    = first_cnt_q == '0;
		s_empty    = second_cnt_q == '0;
		total      = SUMW'(first_cnt_q) + SUMW'(second_cnt_q);
		fit_second = total <= SUMW'(SECOND_DEPTH);
		fit_first  = total <= SUMW'(FIRST_DEPTH);
		is_push    = cmd_q == OP_PUSH;
		is_pop     = cmd_q == OP_POP;
		is_app     = cmd_q == OP_APPEND;
		push_ok    = is_push && !(sel_q ? s_full : f_full);
		pop_ok     = is_pop && !(sel_q ? s_empty : f_empty);
		both       = !f_empty && !s_empty;
		copy_go    = is_app && both && (fit_second || fit_first);
		copy_done  = (rd_idx_q == len_q) && !wr_pend_q;

		if (is_push) begin
			status_nxt = push_ok ? ST_OK : ST_FULL;
		end else if (is_pop) begin
			status_nxt = pop_ok ? ST_OK : ST_EMPTY;
		end else if (is_app) begin
			if (!both) begin
				status_nxt = ST_APPEND_EMPTY;
			end else if (copy_go) begin
				status_nxt = ST_OK;
			end else begin
				status_nxt = ST_NO_FIT;
			end
		end else begin
			status_nxt = ST_OK;
		end

		stat.go_pop    = pop_ok;
		stat.go_copy   = copy_go;
		stat.copy_done = copy_done;
	end

	// Memory ports: a push or a copy write, a pop or a copy read.
	always_comb begin
		f_we    = (ctl.exec && push_ok && !sel_q) || (ctl.copy && !to_second_q && wr_pend_q);
		f_waddr = ctl.copy ? AW1'(XW'(first_cnt_q) + wr_idx_q) : AW1'(first_cnt_q);
		f_wdata = ctl.copy ? s_rdata_q : push_value_q;
		f_raddr = ctl.copy ? AW1'(rd_idx_q) : AW1'(first_cnt_q - 1'b1);

		s_we    = (ctl.exec && push_ok && sel_q) || (ctl.copy && to_second_q && wr_pend_q);
		s_waddr = ctl.copy ? AW2'(XW'(second_cnt_q) + wr_idx_q) : AW2'(second_cnt_q);
		s_wdata = ctl.copy ? f_rdata_q : push_value_q;
		s_raddr = ctl.copy ? AW2'(rd_idx_q) : AW2'(second_cnt_q - 1'b1);
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			f_mem[f_waddr] <= f_wdata;
		end
		f_rdata_q <= f_mem[f_raddr];
	end

	always_ff @(posedge clk) begin
		if (s_we) begin
			s_mem[s_waddr] <= s_wdata;
		end
		s_rdata_q <= s_mem[s_raddr];
	end

	// Input word and result registers.
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			cmd_q        <= cmd;
			sel_q        <= which_stack;
			push_value_q <= push_value;
		end
		if (ctl.exec) begin
			status_q    <= status_nxt;
			pop_value_q <= '0;
			target_q    <= copy_go && fit_second;
		end
		if (ctl.pop_cap) begin
			pop_value_q <= sel_q ? s_rdata_q : f_rdata_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_cnt_q  <= '0;
			second_cnt_q <= '0;
			len_q        <= '0;
			rd_idx_q     <= '0;
			wr_idx_q     <= '0;
			wr_pend_q    <= 1'b0;
			to_second_q  <= 1'b0;
		end else if (ctl.exec) begin
			if (push_ok) begin
				if (sel_q) begin
					second_cnt_q <= second_cnt_q + 1'b1;
				end else begin
					first_cnt_q <= first_cnt_q + 1'b1;
				end
			end
			if (pop_ok) begin
				if (sel_q) begin
					second_cnt_q <= second_cnt_q - 1'b1;
				end else begin
					first_cnt_q <= first_cnt_q - 1'b1;
				end
			end
			if (copy_go) begin
				to_second_q <= fit_second;
				len_q       <= fit_second ? XW'(first_cnt_q) : XW'(second_cnt_q);
				rd_idx_q    <= '0;
				wr_idx_q    <= '0;
				wr_pend_q   <= 1'b0;
			end
		end else if (ctl.copy) begin
			// One source word is read per cycle and written to the top of the
			// other stack in the following cycle.
			if (rd_idx_q != len_q) begin
				rd_idx_q  <= rd_idx_q + 1'b1;
				wr_pend_q <= 1'b1;
			end else begin
				wr_pend_q <= 1'b0;
			end
			if (wr_pend_q) begin
				wr_idx_q <= wr_idx_q + 1'b1;
			end
			if (copy_done) begin
				if (to_second_q) begin
					second_cnt_q <= CW2'(XW'(second_cnt_q) + len_q);
				end else begin
					first_cnt_q <= CW1'(XW'(first_cnt_q) + len_q);
				end
			end
		end
	end

	assign status        = status_q;
	assign pop_value     = pop_value_q;
	assign append_target = target_q;

endmodule

/* hdl/dual_stack_with_append_core.sv */
// Top level of the dual stack with append block.
// Depends on dsa_pkg, dsa_ctrl and dsa_dp.
//
// A command word (cmd, which_stack, push_value) is taken at a rising edge
// with start high and busy low. Each command gives one result word on
// status, pop_value and append_target, marked by done, which is high for
// a single cycle. The receiver cannot stall; the result registers hold
// until the next command executes.
// From the accepting edge to the done cycle, push, a rejected pop or
// append, and the unused code pass through the execute and response
// states; a successful pop adds a read state, as the stack memory has a
// registered read port. A copying append adds a copy state, where the
// copy engine moves one word per cycle over the source read port and the
// target write port. busy is low again in the done cycle, so a new
// command can follow right behind.
// Reset clears both counts and returns the controller to idle; the stack
// memories are not cleared and need no clearing pass.
module dual_stack_with_append_core #(
	parameter int FIRST_DEPTH  = dsa_pkg::FIRST_DEPTH_DEF,
	parameter int SECOND_DEPTH = dsa_pkg::SECOND_DEPTH_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         cmd,
	input  logic               which_stack,
	input  logic signed [31:0] push_value,
	output logic               done,
	output logic [2:0]         status,
	output logic signed [31:0] pop_value,
	output logic               append_target
);
	import dsa_pkg::*;

	dsa_ctl_t  ctl;
	dsa_stat_t stat;

	dsa_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.ctl    (ctl),
		.busy   (busy),
		.done   (done)
	);

	dsa_dp #(
		.FIRST_DEPTH  (FIRST_DEPTH),
		.SECOND_DEPTH (SECOND_DEPTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.ctl           (ctl),
		.stat          (stat),
		.cmd           (cmd),
		.which_stack   (which_stack),
		.push_value    (push_value),
		.status        (status),
		.pop_value     (pop_value),
		.append_target (append_target)
	);

endmodule
